[src/tce_pkg.sv]
package tce_pkg;

	localparam int KIND_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int ADDR_W  = 11;
	localparam int CELL_W  = 16;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
	localparam int unsigned       TAB_STEP   = 8;

	typedef struct packed {
		logic load_item;
		logic exec_put;
		logic exec_clear;
		logic exec_read;
		logic scroll_rd;
		logic scroll_wr;
		logic blank_wr;
		logic load_out;
	} tce_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              scroll_need;
		logic              copy_last;
		logic              blank_last;
	} tce_status_t;

endpackage

[src/text_console_engine.sv]
// text console engine: a COLUMNS x ROWS store of 16-bit cells (attribute high,
// character low) with a cursor, in one single-port memory.
// input channel (in_valid/in_ready) carries kind, char_code, colors and cell_address;
// output channel (out_valid/out_ready) returns cursor_location and cell_data,
// exactly one result per input transaction, in order.
// work after acceptance, all limited by the single memory port, runs through these states:
//   put, read, unused kind : the execute state, then the done state
//   put that scrolls       : execute, then the scroll read and scroll write states
//                            (a read and a write per moved cell, then one blanking row)
//   clear                  : execute, then the blanking state (one blank write per cell)
// after reset the cursor is home and a clearing pass writes blanks to all
// COLUMNS*ROWS cells, one per cycle, with in_ready low for those cycles.
// one transaction is worked on at a time; the next may be accepted while a result
// waits in the output register, and a stalled receiver holds the finished
// transaction in the done state until the register frees up.
module text_console_engine #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tce_pkg::KIND_W-1:0]    kind,
	input  logic [tce_pkg::CHAR_W-1:0]    char_code,
	input  logic [tce_pkg::COLOR_W-1:0]   bg_color,
	input  logic [tce_pkg::COLOR_W-1:0]   fg_color,
	input  logic [tce_pkg::ADDR_W-1:0]    cell_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tce_pkg::ADDR_W-1:0]    cursor_location,
	output logic [tce_pkg::CELL_W-1:0]    cell_data
);
	import tce_pkg::*;

	tce_cmd_t    cmd;
	tce_status_t status;

	tce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tce_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.kind           (kind),
		.char_code      (char_code),
		.bg_color       (bg_color),
		.fg_color       (fg_color),
		.cell_address   (cell_address),
		.cursor_location(cursor_location),
		.cell_data      (cell_data)
	);

endmodule

[src/tce_ram.sv]
module tce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/tce_ctrl.sv]
module tce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tce_pkg::tce_status_t status,
	output tce_pkg::tce_cmd_t   cmd
);
	import tce_pkg::*;

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_SCR_RD = 7'b0001000,
		S_SCR_WR = 7'b0010000,
		S_BLANK  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_INIT: begin
				cmd.blank_wr = 1'b1;
				if (status.blank_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (status.kind)
					KIND_PUT: begin
						cmd.exec_put = 1'b1;
						state_d = status.scroll_need ? S_SCR_RD : S_DONE;
					end
					KIND_CLEAR: begin
						cmd.exec_clear = 1'b1;
						state_d = S_BLANK;
					end
					KIND_READ: begin
						cmd.exec_read = 1'b1;
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_SCR_RD: begin
				cmd.scroll_rd = 1'b1;
				state_d = S_SCR_WR;
			end
			S_SCR_WR: begin
				cmd.scroll_wr = 1'b1;
				state_d = status.copy_last ? S_BLANK : S_SCR_RD;
			end
			S_BLANK: begin
				cmd.blank_wr = 1'b1;
				if (status.blank_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/tce_datapath.sv]
module tce_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tce_pkg::tce_cmd_t             cmd,
	output tce_pkg::tce_status_t          status,
	input  logic [tce_pkg::KIND_W-1:0]    kind,
	input  logic [tce_pkg::CHAR_W-1:0]    char_code,
	input  logic [tce_pkg::COLOR_W-1:0]   bg_color,
	input  logic [tce_pkg::COLOR_W-1:0]   fg_color,
	input  logic [tce_pkg::ADDR_W-1:0]    cell_address,
	output logic [tce_pkg::ADDR_W-1:0]    cursor_location,
	output logic [tce_pkg::CELL_W-1:0]    cell_data
);
	import tce_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int CXW   = $clog2(COLUMNS + 8);
	localparam int RXW   = $clog2(ROWS + 1);
	localparam logic [AW-1:0] COPY_LAST  = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0] BLANK_LAST = AW'(CELLS - 1);

	logic [KIND_W-1:0]  kind_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COLOR_W-1:0] back_q;
	logic [COLOR_W-1:0] fore_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [AW-1:0]      ptr_q;
	logic [ADDR_W-1:0]  loc_q;
	logic [CELL_W-1:0]  data_q;

	logic [31:0]        cur_idx;
	logic [31:0]        rd_addr;
	logic               rd_in_range;
	logic [CW-1:0]      col_n;
	logic [RW-1:0]      row_n;
	logic               put_wr;
	logic               scroll;

	logic [AW-1:0]      ram_addr;
	logic               ram_we;
	logic               ram_re;
	logic [CELL_W-1:0]  ram_wdata;
	logic [CELL_W-1:0]  ram_rdata;

	assign cur_idx     = 32'(row_q) * 32'(COLUMNS) + 32'(col_q);
	assign rd_addr     = 32'(addr_q);
	assign rd_in_range = rd_addr < 32'(CELLS);

	// cursor motion for a put, before any scroll
	always_comb begin
		logic [CXW-1:0] cx;
		logic [RXW-1:0] rx;
		cx = CXW'(col_q);
		rx = RXW'(row_q);
		put_wr = 1'b0;
		case (char_q)
			CH_BS: begin
				if (col_q != '0) begin
					cx = cx - CXW'(1);
				end
			end
			CH_TAB: begin
				cx = (cx + CXW'(TAB_STEP)) & ~CXW'(TAB_STEP - 1);
			end
			CH_CR: begin
				cx = '0;
			end
			CH_LF: begin
				cx = '0;
				rx = rx + RXW'(1);
			end
			default: begin
				if (!char_q[CHAR_W-1] && char_q >= CH_SPACE) begin
					put_wr = 1'b1;
					cx = cx + CXW'(1);
				end
			end
		endcase
		if (cx >= CXW'(COLUMNS)) begin
			cx = '0;
			rx = rx + RXW'(1);
		end
		scroll = rx >= RXW'(ROWS);
		col_n = CW'(cx);
		row_n = scroll ? RW'(ROWS - 1) : RW'(rx);
	end

	always_comb begin
		ram_addr = ptr_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_wdata = BLANK_CELL;
		if (cmd.exec_put) begin
			ram_addr = cur_idx[AW-1:0];
			ram_we = put_wr;
			ram_wdata = {back_q, fore_q, char_q};
		end else if (cmd.exec_read) begin
			ram_addr = rd_addr[AW-1:0];
			ram_re = rd_in_range;
		end else if (cmd.scroll_rd) begin
			ram_addr = ptr_q + AW'(COLUMNS);
			ram_re = 1'b1;
		end else if (cmd.scroll_wr) begin
			ram_we = 1'b1;
			ram_wdata = ram_rdata;
		end else if (cmd.blank_wr) begin
			ram_we = 1'b1;
		end
	end

	tce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.re   (ram_re),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.exec_put) begin
				col_q <= col_n;
				row_q <= row_n;
				ptr_q <= '0;
			end else if (cmd.exec_clear) begin
				col_q <= '0;
				row_q <= '0;
				ptr_q <= '0;
			end else if (cmd.scroll_wr || cmd.blank_wr) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			char_q <= char_code;
			back_q <= bg_color;
			fore_q <= fg_color;
			addr_q <= cell_address;
		end
		if (cmd.load_out) begin
			loc_q <= cur_idx[ADDR_W-1:0];
			data_q <= (kind_q == KIND_READ && rd_in_range) ? ram_rdata : '0;
		end
	end

	assign status.kind        = kind_q;
	assign status.scroll_need = scroll;
	assign status.copy_last   = (ptr_q == COPY_LAST);
	assign status.blank_last  = (ptr_q == BLANK_LAST);

	assign cursor_location = loc_q;
	assign cell_data       = data_q;

endmodule

[src/tce_checker.sv]
module tce_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tce_pkg::ADDR_W-1:0]    cursor_location,
	input logic [tce_pkg::CELL_W-1:0]    cell_data
);
	import tce_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] open_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// transactions accepted but whose result has not been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_location) && $stable(cell_data))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input ready right after a transaction");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 2'd0)
		else $error("result without an accepted transaction");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("too many transactions in flight");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(cursor_location) < 32'(CELLS)) || (CELLS > 2048))
		else $error("cursor location beyond the screen");

endmodule

bind text_console_engine tce_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tce_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.cursor_location(cursor_location),
	.cell_data      (cell_data)
);

[bench/tb_text_console_engine.sv]
module tb_text_console_engine;
	import tce_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [CHAR_W-1:0] CTRL_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CTRL_LAST   = 8'h1F;
	localparam logic [CHAR_W-1:0] PRINT_LAST  = 8'h7F;
	localparam logic [CHAR_W-1:0] HIGH_FIRST  = 8'h80;
	localparam logic [CHAR_W-1:0] HIGH_LAST   = 8'hFF;

	localparam int RANDOM_ITEMS = 110;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 4000;
	localparam int LIMIT        = 3000000;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] back;
		logic [COLOR_W-1:0] fore;
		logic [ADDR_W-1:0]  addr;
		bit                 drain;
	} console_item_t;

	typedef struct {
		logic [ADDR_W-1:0] cursor;
		logic [CELL_W-1:0] data;
	} console_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind = '0;
	logic [CHAR_W-1:0]   char_code = '0;
	logic [COLOR_W-1:0]  bg_color = '0;
	logic [COLOR_W-1:0]  fg_color = '0;
	logic [ADDR_W-1:0]   cell_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ADDR_W-1:0]   cursor_location;
	logic [CELL_W-1:0]   cell_data;

	text_console_engine #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.char_code(char_code),
		.bg_color(bg_color),
		.fg_color(fg_color),
		.cell_address(cell_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_location(cursor_location),
		.cell_data(cell_data)
	);

	always #4 clk = ~clk;

	// screen image and cursor as the block should hold them
	logic [CELL_W-1:0] screen_image [0:CELLS-1];
	int unsigned       cur_col;
	int unsigned       cur_row;

	console_item_t     input_backlog [$];
	console_result_t   awaited_results [$];
	console_item_t     active_item;

	int  items_total;
	int  items_sent;
	int  results_seen;
	int  mismatch_count;
	int  scrolls_seen;
	int  clears_seen;
	int  reads_seen;
	int  cycle_count;
	int  gap_left;
	int  hold_left;
	bit  steady_feed;
	bit  steady_drain;
	bit  drain_next;

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_image[i] = BLANK_CELL;
	endfunction

	function automatic void put_console_char(logic [CHAR_W-1:0] c, logic [7:0] attr);
		int unsigned idx;
		if (c == CH_BS && cur_col != 0) begin
			cur_col--;
		end else if (c == CH_TAB) begin
			cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
		end else if (c == CH_CR) begin
			cur_col = 0;
		end else if (c == CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (c >= CH_SPACE && c < HIGH_FIRST) begin
			idx = cur_row * COLUMNS + cur_col;
			if (idx < CELLS)
				screen_image[idx] = {attr, c};
			cur_col++;
		end
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= ROWS) begin
			for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
				screen_image[i] = screen_image[i + COLUMNS];
			for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
				screen_image[i] = BLANK_CELL;
			cur_row = ROWS - 1;
			scrolls_seen++;
		end
	endfunction

	// works out the result of one accepted transaction and queues it
	function automatic void apply_console_item(console_item_t it);
		console_result_t res;
		res.data = '0;
		case (it.kind)
			KIND_PUT: begin
				put_console_char(it.ch, {it.back, it.fore});
			end
			KIND_CLEAR: begin
				blank_screen();
				cur_col = 0;
				cur_row = 0;
				clears_seen++;
			end
			KIND_READ: begin
				reads_seen++;
				if (it.addr < CELLS)
					res.data = screen_image[it.addr];
			end
			default: begin
			end
		endcase
		res.cursor = ADDR_W'(cur_row * COLUMNS + cur_col);
		awaited_results.push_back(res);
	endfunction

	function automatic void push_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] c,
			logic [COLOR_W-1:0] b, logic [COLOR_W-1:0] f, logic [ADDR_W-1:0] a);
		console_item_t it;
		it.kind = k;
		it.ch = c;
		it.back = b;
		it.fore = f;
		it.addr = a;
		it.drain = drain_next;
		drain_next = 0;
		input_backlog.push_back(it);
	endfunction

	function automatic void push_put(logic [CHAR_W-1:0] c);
		push_item(KIND_PUT, c, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)),
			ADDR_W'($urandom));
	endfunction

	function automatic void build_stimulus();
		int random_count;
		int lf_since_clear;
		int pick;
		int len;
		bit drain_set;
		logic [COLOR_W-1:0] b;
		logic [COLOR_W-1:0] f;
		logic [ADDR_W-1:0]  a;

		// directed: printable extremes, ignored bytes, cursor controls, reads, an unused kind, clear
		push_item(KIND_READ, 8'h00, 4'h0, 4'h0, 11'd0);
		push_item(KIND_PUT, CH_SPACE, 4'h0, 4'h0, 11'd0);
		push_item(KIND_PUT, PRINT_LAST, 4'hF, 4'hF, 11'd2047);
		push_item(KIND_PUT, HIGH_FIRST, 4'h3, 4'hC, 11'd0);
		push_item(KIND_PUT, HIGH_LAST, 4'hC, 4'h3, 11'd0);
		push_item(KIND_PUT, CTRL_NUL, 4'h1, 4'h2, 11'd0);
		push_item(KIND_PUT, CTRL_LAST, 4'h2, 4'h1, 11'd0);
		push_item(KIND_PUT, CH_BS, 4'h0, 4'h0, 11'd0);
		push_item(KIND_PUT, 8'h41, 4'h5, 4'hA, 11'd0);
		push_item(KIND_PUT, CH_CR, 4'h0, 4'h0, 11'd0);
		// backspace at column zero leaves the cursor alone
		push_item(KIND_PUT, CH_BS, 4'h0, 4'h0, 11'd0);
		push_item(KIND_READ, 8'hFF, 4'hF, 4'hF, 11'd0);
		push_item(KIND_READ, 8'h00, 4'h0, 4'h0, 11'd1);
		// ten tabs run off the last column and wrap to the next row
		for (int i = 0; i < 10; i++)
			push_item(KIND_PUT, CH_TAB, 4'h0, 4'h0, 11'd0);
		push_item(KIND_PUT, CH_LF, 4'h0, 4'h0, 11'd0);
		push_item(KIND_READ, 8'h00, 4'h0, 4'h0, 11'd2047);
		push_item(KIND_READ, 8'h00, 4'h0, 4'h0, 11'(CELLS));
		push_item(KIND_UNUSED, 8'hA5, 4'h9, 4'h6, 11'd1234);
		push_item(KIND_CLEAR, 8'h5A, 4'h6, 4'h9, 11'd813);

		random_count = 0;
		lf_since_clear = 0;
		drain_set = 0;
		// keep going until the cursor has surely hit the bottom row a number of times
		while (random_count < RANDOM_ITEMS || lf_since_clear < 26) begin
			if (random_count >= 60 && !drain_set) begin
				drain_next = 1;
				drain_set = 1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// a run of text, usually ended by a new line
				len = $urandom_range(1, 8);
				b = COLOR_W'($urandom_range(0, 15));
				f = COLOR_W'($urandom_range(0, 15));
				for (int i = 0; i < len; i++)
					push_item(KIND_PUT, CHAR_W'($urandom_range(CH_SPACE, PRINT_LAST)), b, f,
						ADDR_W'($urandom));
				random_count += len;
				pick = $urandom_range(0, 99);
				if (pick < 20) begin
					push_put(CH_CR);
					random_count++;
				end
				if (pick < 70) begin
					push_put(CH_LF);
					random_count++;
					lf_since_clear++;
				end
			end else if (pick < 52) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					push_put(CH_TAB);
				random_count += len;
			end else if (pick < 58) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++)
					push_put(CH_BS);
				random_count += len;
			end else if (pick < 72) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					a = ADDR_W'($urandom_range((ROWS - 3) * COLUMNS, CELLS - 1));
				else if (pick < 9)
					a = ADDR_W'($urandom_range(0, CELLS - 1));
				else
					a = ADDR_W'($urandom_range(CELLS, 2047));
				push_item(KIND_READ, CHAR_W'($urandom), COLOR_W'($urandom_range(0, 15)),
					COLOR_W'($urandom_range(0, 15)), a);
				random_count++;
			end else if (pick < 86) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					push_put(CH_LF);
				random_count += len;
				lf_since_clear += len;
			end else if (pick < 94) begin
				// noise the block should mostly shrug off; a control byte may be a cursor control
				pick = $urandom_range(0, 2);
				if (pick == 0)
					push_put(CHAR_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
				else if (pick == 1)
					push_put(CHAR_W'($urandom_range(CTRL_NUL, CTRL_LAST)));
				else
					push_item(KIND_UNUSED, CHAR_W'($urandom), COLOR_W'($urandom_range(0, 15)),
						COLOR_W'($urandom_range(0, 15)), ADDR_W'($urandom));
			end else if (pick < 95) begin
				push_item(KIND_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom_range(0, 15)),
					COLOR_W'($urandom_range(0, 15)), ADDR_W'($urandom));
				random_count++;
				lf_since_clear = 0;
			end else begin
				push_put(CHAR_W'($urandom));
				random_count++;
			end
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : feed
		console_item_t nxt;
		int gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			gap = gap_left;
			if (in_valid && in_ready) begin
				apply_console_item(active_item);
				items_sent++;
				if ($urandom_range(0, 11) == 0)
					steady_feed = !steady_feed;
				gap = steady_feed ? 0 : $urandom_range(0, 8);
			end
			if (!in_valid || in_ready) begin
				if (gap != 0) begin
					gap_left <= gap - 1;
					in_valid <= 1'b0;
				end else if (input_backlog.size() != 0 &&
						(!input_backlog[0].drain || awaited_results.size() == 0)) begin
					nxt = input_backlog.pop_front();
					active_item <= nxt;
					kind <= nxt.kind;
					char_code <= nxt.ch;
					bg_color <= nxt.back;
					fg_color <= nxt.fore;
					cell_address <= nxt.addr;
					in_valid <= 1'b1;
					gap_left <= 0;
				end else begin
					in_valid <= 1'b0;
					gap_left <= 0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : collect
		console_result_t want;
		int hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			hold = hold_left;
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected transaction: cursor_location %0d cell_data %h",
						cursor_location, cell_data);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (cursor_location !== want.cursor) begin
						$error("cursor_location: expected %0d, actual %0d",
							want.cursor, cursor_location);
						mismatch_count++;
					end
					if (cell_data !== want.data) begin
						$error("cell_data: expected %h, actual %h", want.data, cell_data);
						mismatch_count++;
					end
				end
				results_seen++;
				if ($urandom_range(0, 11) == 0)
					steady_drain = !steady_drain;
				// now and then hold off long enough for the input side to back up
				if (results_seen % 60 == 0)
					hold = LONG_HOLD;
				else
					hold = steady_drain ? 0 : $urandom_range(0, 8);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold - 1;
			end else begin
				out_ready <= 1'b1;
				hold_left <= 0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results awaited",
				cycle_count, awaited_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		blank_screen();
		cur_col = 0;
		cur_row = 0;
		build_stimulus();
		items_total = input_backlog.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (!(items_sent == items_total && awaited_results.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("%0d transactions sent, %0d results checked in %0d cycles",
			items_sent, results_seen, cycle_count);
		$display("covered %0d reads, %0d clears and %0d scrolls", reads_seen, clears_seen,
			scrolls_seen);
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
